FILE: rtl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

    // Default pattern capacity in bytes.
    localparam int PATTERN_MAX_DEF = 64;

    // Pattern byte that matches any run of value bytes.
    localparam logic [7:0] STAR_BYTE = 8'd42;

    // Command carried with each input beat.
    typedef enum logic [1:0] {
        CMD_PATTERN = 2'd0,
        CMD_VALUE   = 2'd1,
        CMD_EMPTY   = 2'd2,
        CMD_IDLE    = 2'd3
    } swm_cmd_t;

    // Decoded operation for the beat being processed this cycle.
    typedef struct packed {
        logic load;   // store one pattern byte
        logic step;   // advance the active set by one value byte
        logic query;  // reset the active set for an empty value
        logic first;  // start of a new pattern or a new value
    } swm_op_t;

endpackage

FILE: rtl/swm_pattern_store.sv
`timescale 1ns / 1ps

module swm_pattern_store
    import swm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  swm_op_t                op,
    input  logic [7:0]             ch,
    output logic [PATTERN_MAX-1:0] star,
    output logic [PATTERN_MAX-1:0] lit_hit,
    output logic [PATTERN_MAX-1:0] start_set,
    output logic [PATTERN_MAX:0]   end_sel,
    output logic                   overflow
);

    localparam int LW = $clog2(PATTERN_MAX + 1);

    logic [7:0]             bytes_reg [PATTERN_MAX];
    logic [LW-1:0]          len_reg;
    logic [LW-1:0]          len_next;
    logic [PATTERN_MAX-1:0] star_reg;
    logic [PATTERN_MAX-1:0] star_next;
    logic [PATTERN_MAX-1:0] valid_reg;
    logic [PATTERN_MAX-1:0] valid_next;
    logic [PATTERN_MAX-1:0] start_reg;
    logic [PATTERN_MAX-1:0] start_next;
    logic                   lead_reg;
    logic                   lead_next;
    logic                   ovf_reg;
    logic                   ovf_next;

    logic [LW-1:0]          len_eff;
    logic                   room;
    logic                   is_star;
    logic                   lead;
    logic [PATTERN_MAX-1:0] hit;

    // Write position: a new pattern restarts at position zero.
    assign len_eff = op.first ? '0 : len_reg;
    assign room    = len_eff < LW'(PATTERN_MAX);
    assign is_star = ch == STAR_BYTE;
    assign lead    = op.first | lead_reg;

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            hit[i] = room && (len_eff == LW'(i));
        end
    end

    // Next pattern bookkeeping. The start set holds the star closure of the
    // empty prefix; bit i stands for position i + 1 and grows while the
    // pattern so far is made of stars only.
    always_comb
    begin
        star_next  = (op.first ? '0 : star_reg) | (hit & {PATTERN_MAX{is_star}});
        valid_next = (op.first ? '0 : valid_reg) | hit;
        start_next = (op.first ? '0 : start_reg) |
                     (hit & {PATTERN_MAX{lead & is_star}});
        lead_next  = room ? (lead & is_star) : lead_reg;
        len_next   = room ? len_eff + LW'(1) : len_eff;
        ovf_next   = !room | (!op.first & ovf_reg);
    end

    // Control state of the stored pattern.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            star_reg  <= '0;
            valid_reg <= '0;
            start_reg <= '0;
            lead_reg  <= 1'b1;
            ovf_reg   <= 1'b0;
        end
        else if (op.load)
        begin
            len_reg   <= len_next;
            star_reg  <= star_next;
            valid_reg <= valid_next;
            start_reg <= start_next;
            lead_reg  <= lead_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Pattern bytes, one register per position.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (op.load && hit[i])
            begin
                bytes_reg[i] <= ch;
            end
        end
    end

    // Per-position literal compare against the incoming value byte.
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            lit_hit[i] = valid_reg[i] & ~star_reg[i] & (bytes_reg[i] == ch);
        end
    end

    // One-hot select of the position equal to the pattern length.
    always_comb
    begin
        for (int j = 0; j <= PATTERN_MAX; j++)
        begin
            end_sel[j] = ((j == 0) ? 1'b1 : valid_reg[(j > 0) ? j - 1 : 0]) &
                         ((j < PATTERN_MAX) ? ~valid_reg[(j < PATTERN_MAX) ? j : 0] : 1'b1);
        end
    end

    assign star      = star_reg;
    assign start_set = start_reg;
    assign overflow  = ovf_reg;

    // The stored length never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

    // Exactly one end position is selected.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(end_sel))
    else $error("end position select not one-hot");

    // Stars are only recorded at stored positions.
    assert property (@(posedge clk) disable iff (!rst_n)
        (star_reg & ~valid_reg) == '0)
    else $error("star bit outside stored pattern");

endmodule

FILE: rtl/swm_active_set.sv
`timescale 1ns / 1ps

module swm_active_set
    import swm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  swm_op_t                op,
    input  logic [PATTERN_MAX-1:0] star,
    input  logic [PATTERN_MAX-1:0] lit_hit,
    input  logic [PATTERN_MAX-1:0] start_set,
    input  logic [PATTERN_MAX:0]   end_sel,
    output logic                   match_next
);

    localparam int W = PATTERN_MAX + 1;

    logic [W-1:0] active_reg;
    logic [W-1:0] active_next;
    logic [W-1:0] start_full;
    logic [W-1:0] base;
    logic [W-1:0] adv;
    logic [W-1:0] star_w;
    logic [W-1:0] sum;
    logic [W-1:0] closed;

    assign start_full = {start_set, 1'b1};
    assign base       = op.first ? start_full : active_reg;
    assign star_w     = {1'b0, star};

    // Advance: a star keeps its bit, a matching literal moves it one up.
    assign adv = ({1'b0, base[PATTERN_MAX-1:0] & star}) |
                 ({base[PATTERN_MAX-1:0] & lit_hit, 1'b0});

    // Star closure as a carry chain: stars propagate, active stars generate.
    assign sum    = star_w + (adv & star_w);
    assign closed = adv | (sum ^ (star_w & ~adv));

    always_comb
    begin
        if (op.load && op.first)
        begin
            active_next = '0;
        end
        else if (op.step)
        begin
            active_next = closed;
        end
        else if (op.query)
        begin
            active_next = start_full;
        end
        else
        begin
            active_next = active_reg;
        end
    end

    assign match_next = |(active_next & end_sel);

    // Active prefix bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

FILE: rtl/star_wildcard_matcher.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                       Beat contents
// s_*       in   tvalid tready tdata tuser tlast  pattern byte, value byte or empty query
// m_*       out  tvalid tready tdata            match result with overflow flag
//
// One beat enters an input register and is processed from there; its
// result, if any, is then registered in the output register.
// A new beat is taken every cycle; the only wait is a result-producing beat
// held while the output register is full and m_tready is low.
// The active set update is one 65-bit carry chain plus a byte compare per
// pattern position, all between the input and result registers.
// Reset clears the pattern length, overflow flag and active set; pattern
// bytes are not cleared and are never read before being written.
module star_wildcard_matcher
    import swm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] ch, [8] first, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    logic                   in_valid_reg;
    swm_cmd_t               cmd_reg;
    logic [7:0]             ch_reg;
    logic                   first_reg;
    logic                   last_reg;

    logic                   out_valid_reg;
    logic                   matched_reg;
    logic                   ovf_out_reg;

    logic                   needs_result;
    logic                   proc;
    swm_op_t                op;

    logic [PATTERN_MAX-1:0] star;
    logic [PATTERN_MAX-1:0] lit_hit;
    logic [PATTERN_MAX-1:0] start_set;
    logic [PATTERN_MAX:0]   end_sel;
    logic                   overflow;
    logic                   match_next;

    // Command decode for the registered beat.
    always_comb
    begin
        op = '0;
        needs_result = 1'b0;
        unique case (cmd_reg)
            CMD_PATTERN:
            begin
                op.load = 1'b1;
            end
            CMD_VALUE:
            begin
                op.step = 1'b1;
                needs_result = last_reg;
            end
            CMD_EMPTY:
            begin
                op.query = 1'b1;
                needs_result = 1'b1;
            end
            CMD_IDLE:
            begin
                op = '0;
            end
            default:
            begin
                op = '0;
            end
        endcase
        op.first = first_reg;
        proc = in_valid_reg && (!needs_result || !out_valid_reg || m_tready);
        if (!proc)
        begin
            op = '0;
        end
    end

    assign s_tready = !in_valid_reg || proc;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            cmd_reg   <= swm_cmd_t'(s_tuser);
            ch_reg    <= s_tdata[7:0];
            first_reg <= s_tdata[8];
            last_reg  <= s_tlast;
        end
    end

    swm_pattern_store #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .ch        (ch_reg),
        .star      (star),
        .lit_hit   (lit_hit),
        .start_set (start_set),
        .end_sel   (end_sel),
        .overflow  (overflow)
    );

    swm_active_set #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_active (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .star       (star),
        .lit_hit    (lit_hit),
        .start_set  (start_set),
        .end_sel    (end_sel),
        .match_next (match_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc && needs_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && needs_result)
        begin
            matched_reg <= match_next && !overflow;
            ovf_out_reg <= overflow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, ovf_out_reg, matched_reg};

    // An overflowed pattern never reports a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(matched_reg && ovf_out_reg))
    else $error("match reported with pattern overflow");

    // A beat that yields a result shows it in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc && needs_result |=> out_valid_reg)
    else $error("result lost after processing");

    // A held beat is kept in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc |=> in_valid_reg && $stable(cmd_reg))
    else $error("held input beat dropped");

endmodule
